// ----- hdl/mbph_pkg.sv -----
// Shared types, register codes and reset values for the meter ballistics
// peak-hold unit. No dependencies.
package mbph_pkg;

  // Default number of bands
  localparam int unsigned BANDS_DEFAULT = 256;

  // Field widths
  localparam int unsigned BAND_W  = 8;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned COEF_W  = 17;
  localparam int unsigned AGE_W   = 8;
  localparam int unsigned IN_W    = BAND_W + LEVEL_W;
  localparam int unsigned OUT_W   = BAND_W + 2 * LEVEL_W;

  // Configuration port
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam logic [COEF_W-1:0] COEF_ONE = 17'h10000;
  localparam logic [AGE_W-1:0]  AGE_MAX  = 8'hFF;

  // Register reset values
  localparam logic [COEF_W-1:0]  ATTACK_RST  = 17'd36045;
  localparam logic [COEF_W-1:0]  RELEASE_RST = 17'd10486;
  localparam logic [AGE_W-1:0]   HOLD_RST    = 8'd21;
  localparam logic [LEVEL_W-1:0] DECAY_RST   = 16'd1180;
  localparam logic               ENABLE_RST  = 1'b1;

  // Register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_ATTACK  = 3'd0,
    REG_RELEASE = 3'd1,
    REG_HOLD    = 3'd2,
    REG_DECAY   = 3'd3,
    REG_ENABLE  = 3'd4
  } mbph_reg_e;

  // Per-band state entry
  typedef struct packed {
    logic [AGE_W-1:0]   age;
    logic [LEVEL_W-1:0] peak;
    logic [LEVEL_W-1:0] level;
  } mbph_entry_t;

  localparam int unsigned ENTRY_W = $bits(mbph_entry_t);

endpackage

// ----- hdl/meter_ballistics_peak_hold_unit.sv -----
// Per-band meter ballistics with peak hold; uses mbph_pkg and mbph_ram.
// An accepted word passes through stage 1 and the output register. Throughput:
// one word per cycle unless the master side stalls. The state RAM (one read, one
// write port) is read on acceptance, written as stage 1 advances, with a bypass path.
// Reset: asynchronous, active low; clears control state and the per-band valid
// bits (an entry not yet written reads as zero); registers take reset values.
module meter_ballistics_peak_hold_unit
  #(
  parameter int unsigned BANDS = mbph_pkg::BANDS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Slave side
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [mbph_pkg::IN_W-1:0]    s_axis_tdata,   // band[7:0], target[23:8]
  // Master side
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [mbph_pkg::OUT_W-1:0]   m_axis_tdata,   // band_out[7:0], level_out[23:8],
                                                       // peak_out[39:24]
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mbph_pkg::PADDR_W-1:0] paddr,
  input  logic [mbph_pkg::PDATA_W-1:0] pwdata,
  output logic [mbph_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  import mbph_pkg::*;

  // The band field is 8 bits wide, so at most 256 entries are reachable.
  localparam int unsigned DEPTH = (BANDS < 256) ? BANDS : 256;
  localparam int unsigned AW    = $clog2(DEPTH);

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [COEF_W-1:0]  attack_q;
  logic [COEF_W-1:0]  release_q;
  logic [AGE_W-1:0]   hold_q;
  logic [LEVEL_W-1:0] decay_q;
  logic               enable_q;
  logic               cfg_wr;
  mbph_reg_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = mbph_reg_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= ATTACK_RST;
      release_q <= RELEASE_RST;
      hold_q    <= HOLD_RST;
      decay_q   <= DECAY_RST;
      enable_q  <= ENABLE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ATTACK:  attack_q  <= pwdata[COEF_W-1:0];
        REG_RELEASE: release_q <= pwdata[COEF_W-1:0];
        REG_HOLD:    hold_q    <= pwdata[AGE_W-1:0];
        REG_DECAY:   decay_q   <= pwdata[LEVEL_W-1:0];
        REG_ENABLE:  enable_q  <= pwdata[0];
        default:     ;
      endcase
    end
  end

  // Read back: zero-extend to the bus width; unused addresses read zero
  always_comb begin
    case (cfg_idx)
      REG_ATTACK:  prdata = PDATA_W'(attack_q);
      REG_RELEASE: prdata = PDATA_W'(release_q);
      REG_HOLD:    prdata = PDATA_W'(hold_q);
      REG_DECAY:   prdata = PDATA_W'(decay_q);
      REG_ENABLE:  prdata = PDATA_W'(enable_q);
      default:     prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Handshake and stage control
  // ------------------------------------------------------------------
  logic [BAND_W-1:0]  in_band;
  logic [LEVEL_W-1:0] in_target;
  logic [AW-1:0]      in_addr;
  logic               in_acc;

  // Stage 1: the accepted word waits here while its RAM read completes
  logic               s1_valid_q;
  logic [BAND_W-1:0]  s1_band_q;
  logic [LEVEL_W-1:0] s1_target_q;
  logic               s1_adv;
  logic               s1_in_range;

  // Output register
  logic               out_valid_q;
  logic [OUT_W-1:0]   out_data_q;

  assign in_band   = s_axis_tdata[BAND_W-1:0];
  assign in_target = s_axis_tdata[IN_W-1:BAND_W];
  assign in_addr   = in_band[AW-1:0];

  // Advance stage 1 whenever the output register is empty or being drained;
  // take a new word whenever stage 1 is empty or advancing.
  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s1_in_range   = (32'(s1_band_q) < BANDS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Band state: RAM, valid bits and bypass
  // ------------------------------------------------------------------
  logic [ENTRY_W-1:0] ram_rdata;
  logic               ram_we;
  logic [DEPTH-1:0]   valid_q;
  logic               vld_rd_q;
  logic               fwd_q;
  mbph_entry_t        fwd_entry_q;
  mbph_entry_t        cur;
  mbph_entry_t        nxt;

  assign ram_we = s1_adv && s1_in_range;

  mbph_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_band_q[AW-1:0]),
    .wdata_i (nxt),
    .re_i    (in_acc),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // Mark each entry once written; an unmarked entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[s1_band_q[AW-1:0]] <= 1'b1;
    end
  end

  // Capture the valid bit alongside the RAM read. When the word ahead writes
  // the same band at the very edge this word reads, the RAM returns stale
  // data: hold the freshly computed entry and use it instead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_rd_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else if (in_acc) begin
      vld_rd_q <= valid_q[in_addr];
      fwd_q    <= ram_we && (s1_band_q == in_band);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_band_q   <= in_band;
      s1_target_q <= in_target;
      fwd_entry_q <= nxt;
    end
  end

  always_comb begin
    if (fwd_q) begin
      cur = fwd_entry_q;
    end else if (vld_rd_q) begin
      cur = mbph_entry_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  // ------------------------------------------------------------------
  // Ballistics: level smoothing then peak tracking
  // ------------------------------------------------------------------
  logic               rising;
  logic [LEVEL_W-1:0] diff;
  logic [COEF_W-1:0]  coef_raw;
  logic [COEF_W-1:0]  coef;
  logic [31:0]        prod;
  logic [LEVEL_W-1:0] step;
  logic [LEVEL_W-1:0] new_level;
  logic [AGE_W-1:0]   age_inc;
  logic [LEVEL_W-1:0] fallen;
  logic [LEVEL_W-1:0] decayed;

  always_comb begin
    // A rising target takes the attack coefficient, equal or falling the
    // release one; coefficients above one saturate to one.
    rising   = s1_target_q > cur.level;
    diff     = rising ? (s1_target_q - cur.level) : (cur.level - s1_target_q);
    coef_raw = rising ? attack_q : release_q;
    coef     = (coef_raw > COEF_ONE) ? COEF_ONE : coef_raw;
    prod     = 32'(diff) * 32'(coef);
    step     = prod[31:16];
    new_level = rising ? (cur.level + step) : (cur.level - step);

    // Age saturates; once past the hold, drop the peak by the decay step,
    // floored at zero and never below the level.
    age_inc = (cur.age != AGE_MAX) ? (cur.age + AGE_W'(1)) : cur.age;
    fallen  = (cur.peak > decay_q) ? (cur.peak - decay_q) : '0;
    decayed = (fallen > new_level) ? fallen : new_level;

    nxt.level = new_level;
    nxt.peak  = cur.peak;
    nxt.age   = cur.age;
    if (enable_q) begin
      if (new_level >= cur.peak) begin
        nxt.peak = new_level;
        nxt.age  = '0;
      end else begin
        nxt.age = age_inc;
        if (age_inc > hold_q) begin
          nxt.peak = decayed;
        end
      end
    end
  end

  // Out-of-range bands report zero level and peak and leave no trace
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      if (s1_in_range) begin
        out_data_q <= {nxt.peak, nxt.level, s1_band_q};
      end else begin
        out_data_q <= {{(2 * LEVEL_W){1'b0}}, s1_band_q};
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- hdl/mbph_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Defaults from mbph_pkg.
module mbph_ram #(
  parameter int unsigned WIDTH = mbph_pkg::ENTRY_W,
  parameter int unsigned DEPTH = mbph_pkg::BANDS_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/mbph_checker.sv -----
// Port-level checks for meter_ballistics_peak_hold_unit, bound to the top
// level below. Uses mbph_pkg.
module mbph_checker #(
  parameter int unsigned BANDS = mbph_pkg::BANDS_DEFAULT
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [mbph_pkg::IN_W-1:0]    s_axis_tdata,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [mbph_pkg::OUT_W-1:0]   m_axis_tdata
);

  import mbph_pkg::*;

  logic [BAND_W-1:0]  out_band;
  logic [LEVEL_W-1:0] out_level;
  logic [LEVEL_W-1:0] out_peak;
  logic               in_word;

  assign out_band  = m_axis_tdata[BAND_W-1:0];
  assign out_level = m_axis_tdata[BAND_W+LEVEL_W-1:BAND_W];
  assign out_peak  = m_axis_tdata[OUT_W-1:BAND_W+LEVEL_W];
  assign in_word   = s_axis_tvalid && s_axis_tready;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // An empty output side never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // Bands beyond the table report zero level and peak
  a_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (32'(out_band) >= BANDS) |-> out_level == '0 && out_peak == '0)
    else $error("out-of-range band gave non-zero level or peak");

  // An accepted word that then finds the output side free leaves stage 1 and
  // shows up on the master side with its band
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_word ##1 (!m_axis_tvalid || m_axis_tready) |=>
      m_axis_tvalid && out_band == $past(s_axis_tdata[BAND_W-1:0], 2))
    else $error("result word missing two cycles after acceptance");

endmodule

bind meter_ballistics_peak_hold_unit mbph_checker #(
  .BANDS (BANDS)
) u_mbph_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- sim/meter_ballistics_peak_hold_unit_tb.sv -----
// Self-checking bench for meter_ballistics_peak_hold_unit: streams band words in, predicts
// level and peak per band, and checks every output word. Depends on mbph_pkg and the RTL.
module meter_ballistics_peak_hold_unit_tb;
  import mbph_pkg::*;

  localparam int unsigned LIMIT      = 400000;  // cycles before the run is declared hung
  localparam int unsigned LONG_STALL = 120;     // receiver hold-off that backs up the input
  localparam int unsigned PHASE_LEN  = 240;     // random words per register setting

  // Output word as it sits on m_axis_tdata: band lowest, then level, then peak
  typedef struct packed {
    logic [LEVEL_W-1:0] peak;
    logic [LEVEL_W-1:0] level;
    logic [BAND_W-1:0]  band;
  } meter_word_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata  = '0;   // band[7:0], target[23:8]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;         // band_out[7:0], level_out[23:8], peak_out[39:24]
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [PADDR_W-1:0]  paddr         = '0;
  logic [PDATA_W-1:0]  pwdata        = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  meter_ballistics_peak_hold_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  // Shadow registers, reset values as the block comes out of reset
  logic [COEF_W-1:0]  atk_coef = ATTACK_RST;
  logic [COEF_W-1:0]  rel_coef = RELEASE_RST;
  logic [AGE_W-1:0]   hold_frm = HOLD_RST;
  logic [LEVEL_W-1:0] decay_amt = DECAY_RST;
  logic               hold_en  = ENABLE_RST;

  // Per-band shadow state, all zero after reset
  logic [LEVEL_W-1:0] lvl_mem [BANDS_DEFAULT];
  logic [LEVEL_W-1:0] pk_mem  [BANDS_DEFAULT];
  logic [AGE_W-1:0]   age_mem [BANDS_DEFAULT];

  logic [IN_W-1:0] pending_words[$];   // band words waiting for the driver
  meter_word_t     meter_words_due[$]; // predicted output words, oldest first

  int unsigned cycles        = 0;
  int unsigned errors        = 0;
  int unsigned words_in      = 0;
  int unsigned words_checked = 0;
  int unsigned decays_seen   = 0;
  int unsigned settings_run  = 0;
  bit          word_taken    = 1'b0;
  bit          long_hold_req = 1'b0;

  initial begin
    for (int i = 0; i < BANDS_DEFAULT; i++) begin
      lvl_mem[i] = '0;
      pk_mem[i]  = '0;
      age_mem[i] = '0;
    end
  end

  // Advance one band by one target and return the word the block should emit.
  // Coefficients above one act as one; the step is truncated toward the old level.
  function automatic meter_word_t ballistics_update(input logic [BAND_W-1:0] b,
                                                    input logic [LEVEL_W-1:0] tgt);
    logic [COEF_W-1:0]  k;
    logic [LEVEL_W-1:0] diff;
    logic [32:0]        prod;
    logic [LEVEL_W-1:0] lvl;
    logic [LEVEL_W-1:0] pk;
    logic [AGE_W-1:0]   age;
    logic [LEVEL_W-1:0] fallen;
    meter_word_t        w;
    lvl = lvl_mem[b];
    if (tgt > lvl) begin
      k    = (atk_coef > COEF_ONE) ? COEF_ONE : atk_coef;
      diff = tgt - lvl;
      prod = 33'(diff) * 33'(k);
      lvl  = lvl + prod[31:16];
    end else begin
      // equal target takes the release path and leaves the level where it is
      k    = (rel_coef > COEF_ONE) ? COEF_ONE : rel_coef;
      diff = lvl - tgt;
      prod = 33'(diff) * 33'(k);
      lvl  = lvl - prod[31:16];
    end
    lvl_mem[b] = lvl;
    pk  = pk_mem[b];
    age = age_mem[b];
    if (hold_en) begin
      if (lvl >= pk) begin
        pk  = lvl;
        age = '0;
      end else begin
        // age saturates, so a hold of 255 frames never expires
        if (age != AGE_MAX) age = age + 1'b1;
        if (age > hold_frm) begin
          fallen = (pk > decay_amt) ? pk - decay_amt : '0;
          pk     = (fallen > lvl) ? fallen : lvl;
          decays_seen++;
        end
      end
      pk_mem[b]  = pk;
      age_mem[b] = age;
    end
    w.band  = b;
    w.level = lvl;
    w.peak  = pk;
    return w;
  endfunction

  // Monitor: predict on every accepted input word, check every accepted output word.
  // Everything is sampled here on the rising edge; the driver reads word_taken later.
  always @(posedge clk_i) begin
    meter_word_t want;
    meter_word_t got;
    word_taken = s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      cycles++;
      if (cycles > LIMIT) begin
        $display("%0t: timeout after %0d cycles, %0d words still due", $time, cycles,
                 meter_words_due.size());
        $display("== FAIL ==");
        $finish;
      end else begin
        if (word_taken) begin
          meter_words_due.insert(meter_words_due.size(),
                                 ballistics_update(s_axis_tdata[BAND_W-1:0],
                                                   s_axis_tdata[IN_W-1:BAND_W]));
          words_in++;
        end
        if (m_axis_tvalid && m_axis_tready) begin
          got = meter_word_t'(m_axis_tdata);
          if (meter_words_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, got %h", $time, got);
          end else begin
            want = meter_words_due.pop_front();
            words_checked++;
            if (got.band !== want.band) begin
              errors++;
              $display("%0t: band mismatch, expected %h, got %h", $time, want.band, got.band);
            end
            if (got.level !== want.level) begin
              errors++;
              $display("%0t: level mismatch on band %h, expected %h, got %h", $time,
                       want.band, want.level, got.level);
            end
            if (got.peak !== want.peak) begin
              errors++;
              $display("%0t: peak mismatch on band %h, expected %h, got %h", $time,
                       want.band, want.peak, got.peak);
            end
          end
        end
      end
    end
  end

  // Driver: offer words in bursts of random length, separated by random gaps.
  // A word on the bus is held until the edge that accepts it.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !word_taken) begin
        // hold the current word
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        if (burst_left == 0) burst_left = $urandom_range(1, 40);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_words.pop_front();
        burst_left--;
        // a third of the bursts run straight into the next one
        if (burst_left == 0 && $urandom_range(0, 2) != 0) gap_left = $urandom_range(1, 6);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: walk a 16-bit ready pattern, redrawn each lap, sometimes all ones.
  // A long hold-off, when asked for, is counted down here.
  logic [15:0] rx_pat   = 16'hFFFF;
  int unsigned rx_phase = 0;
  int unsigned rx_stall = 0;

  always @(negedge clk_i) begin
    if (rx_stall > 0) begin
      rx_stall--;
      m_axis_tready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      rx_stall      = LONG_STALL - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rx_pat[rx_phase];
      rx_phase = (rx_phase + 1) % 16;
      if (rx_phase == 0) rx_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    end
  end

  // Register write: setup cycle, then access cycle held until pready
  task automatic reg_write(input mbph_reg_e idx, input logic [PDATA_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ATTACK:  atk_coef  = val[COEF_W-1:0];
      REG_RELEASE: rel_coef  = val[COEF_W-1:0];
      REG_HOLD:    hold_frm  = val[AGE_W-1:0];
      REG_DECAY:   decay_amt = val[LEVEL_W-1:0];
      REG_ENABLE:  hold_en   = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [COEF_W-1:0] atk, input logic [COEF_W-1:0] rel,
                               input logic [AGE_W-1:0] hold, input logic [LEVEL_W-1:0] dec,
                               input logic en);
    reg_write(REG_ATTACK, PDATA_W'(atk));
    reg_write(REG_RELEASE, PDATA_W'(rel));
    reg_write(REG_HOLD, PDATA_W'(hold));
    reg_write(REG_DECAY, PDATA_W'(dec));
    reg_write(REG_ENABLE, PDATA_W'(en));
    settings_run++;
  endtask

  function automatic void send(input logic [BAND_W-1:0] b, input logic [LEVEL_W-1:0] tgt);
    pending_words.insert(pending_words.size(), {tgt, b});
  endfunction

  // Wait until every queued word has gone in and every predicted word has come out,
  // then let the pipeline settle.
  task automatic drain;
    while (pending_words.size() != 0 || s_axis_tvalid || meter_words_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly meter-like traffic: a loud hit on a band followed by a quieter tail,
  // sometimes interleaved with another of the low bands, so ages build up and peaks decay.
  // The rest is noise over the full band and target range.
  task automatic fill_random(input int n);
    int                 left;
    int                 run;
    logic [BAND_W-1:0]  b;
    logic [BAND_W-1:0]  b2;
    logic [LEVEL_W-1:0] t;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        send(8'($urandom), 16'($urandom));
        left--;
      end else begin
        b  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
        b2 = 8'($urandom_range(0, 11));
        send(b, 16'($urandom_range(16'h8000, 16'hFFFF)));
        left--;
        run = $urandom_range(3, 40);
        for (int k = 0; k < run && left > 0; k++) begin
          case ($urandom_range(0, 7))
            0:       t = '0;
            1:       t = lvl_mem[b];  // equal to the current shadow level
            default: t = 16'($urandom_range(0, 16'h7FFF) >> $urandom_range(0, 8));
          endcase
          send(($urandom_range(0, 3) == 0) ? b2 : b, t);
          left--;
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset registers: extremes of band and target, rise, fall and equal target
    send(8'h00, 16'hFFFF);
    send(8'h00, 16'hFFFF);
    send(8'h00, 16'hFFFF);
    send(8'h00, 16'h8000);
    send(8'h00, 16'h0000);
    send(8'h00, 16'h0000);
    send(8'hFF, 16'hFFFF);
    send(8'hFF, 16'h0000);
    send(8'h07, 16'h0000);
    send(8'hAA, 16'h5555);
    send(8'h55, 16'hAAAA);
    drain();

    // Coefficients above one, no hold, full decay: the peak drops straight onto the level
    apply_setting(17'h1FFFF, COEF_ONE, 8'd0, 16'hFFFF, 1'b1);
    send(8'h01, 16'hFFFF);
    send(8'h01, 16'h1234);
    send(8'h01, 16'h1234);
    send(8'h02, 16'hFFFF);
    send(8'h02, 16'h0000);
    drain();

    // Peak hold off with frozen level, then off with instant attack
    apply_setting('0, '0, HOLD_RST, DECAY_RST, 1'b0);
    send(8'h00, 16'hFFFF);
    send(8'h00, 16'h0000);
    send(8'h03, 16'hFFFF);
    send(8'hFF, 16'h8000);
    drain();
    reg_write(REG_ATTACK, PDATA_W'(COEF_ONE));
    send(8'h03, 16'hFFFF);
    send(8'h03, 16'h0001);
    drain();

    // Random traffic over a sweep of settings, extremes first
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_setting(ATTACK_RST, RELEASE_RST, HOLD_RST, DECAY_RST, 1'b1);
        1: apply_setting(COEF_ONE, COEF_ONE, 8'd0, 16'hFFFF, 1'b1);
        2: apply_setting('0, '0, 8'd255, '0, 1'b1);
        3: apply_setting(17'h1FFFF, 17'h1FFFF, 8'd1, 16'd1, 1'b1);
        4: apply_setting(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
                         8'($urandom), 16'($urandom), 1'b1);
        5: apply_setting(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
                         8'($urandom_range(0, 30)), 16'($urandom), 1'b0);
        6: apply_setting(17'd1, 17'd1, 8'd254, 16'd300, 1'b1);
        default: apply_setting(17'($urandom), 17'($urandom), 8'($urandom_range(0, 30)),
                               16'($urandom_range(0, 4000)), 1'($urandom));
      endcase
      fill_random(PHASE_LEN);
      // hold the receiver off long enough for the block to back up its input
      if (p == 1) long_hold_req = 1'b1;
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (meter_words_due.size() != 0) begin
      errors++;
      $display("%0t: %0d predicted words never arrived", $time, meter_words_due.size());
    end
    $display("Ran %0d band words over %0d register settings; %0d output words checked.",
             words_in, settings_run, words_checked);
    $display("Predicted %0d peak decay steps; %0d mismatches.", decays_seen, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mbph_pkg.sv
hdl/mbph_ram.sv
hdl/meter_ballistics_peak_hold_unit.sv
hdl/mbph_checker.sv
sim/meter_ballistics_peak_hold_unit_tb.sv
